// File: rtl/fbc_pkg.sv
package fbc_pkg;

	// Widths of the fixed-size fields.
	localparam int unsigned VEC_W    = 32;
	localparam int unsigned HALF_W   = 31;
	localparam int unsigned SLOT_W   = 3;
	localparam int unsigned MASK_W   = 6;

	// Stored plane normal: signed Q1.14 component and its magnitude.
	localparam int unsigned NORM_W   = 16;
	localparam int unsigned ABS_W    = 15;
	localparam int          NORM_MAX = 32767;

	// The Q23.8 offset is aligned to the Q.22 dot product by this shift.
	localparam int unsigned OFFSET_SHIFT = 14;

	// Defaults for the top-level parameters.
	localparam int unsigned NUM_PLANES_DEF  = 6;
	localparam int unsigned COORD_WIDTH_DEF = 32;

	// Item kinds.
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEST = 1'b1
	} op_t;

	// Control fields that travel with each item along the cell chain.
	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic              visible;
		logic [MASK_W-1:0] mask;
	} ctrl_t;

endpackage

// File: rtl/frustum_box_cull_unit.sv
// Box culling against up to six clip planes. Each plane lives in its own cell of a chain;
// every item, load or test, walks the chain in order, so a load changes only the tests that
// were accepted after it. A load (operation 0) stores a normal, saturated to +-32767 per
// component, and an offset into the cell of its slot, and gives no result. A test (operation 1)
// checks the box against the planes set in in_mask and gives one result: visible is cleared
// and out_mask zeroed when the box lies wholly behind a plane; otherwise out_mask holds the
// checked planes the box straddles. One item is taken per cycle while cmd_stall is low. Each
// cell has two register stages (one multiplier stage, one sum stage), the first loaded at the
// transfer edge itself, and the decision of the last cell goes straight into the output
// register. Slots must be loaded before they are tested.
module frustum_box_cull_unit import fbc_pkg::*; #(
	parameter int unsigned NUM_PLANES  = NUM_PLANES_DEF,
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic                     operation,
	input  logic [SLOT_W-1:0]        plane_slot,
	input  logic signed [VEC_W-1:0]  vec_x,
	input  logic signed [VEC_W-1:0]  vec_y,
	input  logic signed [VEC_W-1:0]  vec_z,
	input  logic [HALF_W-1:0]        half_x,
	input  logic [HALF_W-1:0]        half_y,
	input  logic [HALF_W-1:0]        half_z,
	input  logic signed [VEC_W-1:0]  plane_offset,
	input  logic [MASK_W-1:0]        in_mask,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic                     visible,
	output logic [MASK_W-1:0]        out_mask
);

	localparam int unsigned CW = (COORD_WIDTH > VEC_W) ? VEC_W : COORD_WIDTH;
	localparam int unsigned NC = (NUM_PLANES > MASK_W) ? MASK_W : NUM_PLANES;
	localparam logic [MASK_W-1:0] MASK_LIVE = MASK_W'((1 << NC) - 1);

	function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [VEC_W-1:0] v);
		logic signed [NORM_W-1:0] r;
		if (v > NORM_MAX) begin
			r = NORM_W'(NORM_MAX);
		end else if (v < -NORM_MAX) begin
			r = NORM_W'(-NORM_MAX);
		end else begin
			r = v[NORM_W-1:0];
		end
		return r;
	endfunction

	logic signed [VEC_W-1:0]  vec_in [3];
	logic        [HALF_W-1:0] half_in [3];
	logic signed [NORM_W-1:0] n_sat [3];
	logic        [NORM_W-1:0] n_abs [3];
	logic signed [CW-1:0]     entry_vec [3];
	logic        [CW-2:0]     entry_half [3];

	logic                 ch_valid [NC+1];
	logic                 ch_ready [NC+1];
	ctrl_t                ch_ctrl  [NC+1];
	logic signed [CW-1:0] ch_vec   [NC+1][3];
	logic        [CW-2:0] ch_half  [NC+1][3];
	logic signed [CW-1:0] ch_offs  [NC+1];

	logic                 res_valid_q;
	logic                 visible_q;
	logic [MASK_W-1:0]    out_mask_q;
	logic                 res_free;
	logic                 res_take;
	logic                 last_is_test;

	assign vec_in  = '{vec_x, vec_y, vec_z};
	assign half_in = '{half_x, half_y, half_z};

	// Entry: a load carries its saturated normal in the vector lanes and the
	// magnitudes in the half-size lanes; a test carries its box unchanged.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_sat[k] = sat_norm(vec_in[k]);
			n_abs[k] = n_sat[k][NORM_W-1] ? NORM_W'(-n_sat[k]) : n_sat[k];
			if (operation == OP_LOAD) begin
				entry_vec[k]  = CW'(n_sat[k]);
				entry_half[k] = (CW-1)'(n_abs[k][ABS_W-1:0]);
			end else begin
				entry_vec[k]  = vec_in[k][CW-1:0];
				entry_half[k] = half_in[k][CW-2:0];
			end
		end
	end

	assign ch_vec[0]   = entry_vec;
	assign ch_half[0]  = entry_half;
	assign ch_offs[0]  = plane_offset[CW-1:0];
	assign ch_valid[0] = cmd_valid;
	assign cmd_stall   = !ch_ready[0];
	assign ch_ctrl[0]  = '{op: op_t'(operation), slot: plane_slot, visible: 1'b1,
		mask: in_mask & MASK_LIVE};

	// One cell per plane.
	for (genvar i = 0; i < NC; i++) begin : g_cell
		fbc_cell #(
			.CELL_INDEX (i),
			.CW         (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (ch_valid[i]),
			.in_ready   (ch_ready[i]),
			.in_ctrl    (ch_ctrl[i]),
			.in_vec     (ch_vec[i]),
			.in_half    (ch_half[i]),
			.in_offset  (ch_offs[i]),
			.out_valid  (ch_valid[i+1]),
			.out_ready  (ch_ready[i+1]),
			.out_ctrl   (ch_ctrl[i+1]),
			.out_vec    (ch_vec[i+1]),
			.out_half   (ch_half[i+1]),
			.out_offset (ch_offs[i+1])
		);
	end

	// Loads leave the chain here; tests go to the output register.
	assign last_is_test = ch_ctrl[NC].op == OP_TEST;
	assign res_free     = !res_valid_q || !res_stall;
	assign ch_ready[NC] = !last_is_test || res_free;
	assign res_take     = ch_valid[NC] && last_is_test && res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= res_take;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			visible_q  <= ch_ctrl[NC].visible;
			out_mask_q <= ch_ctrl[NC].mask;
		end
	end

	assign res_valid = res_valid_q;
	assign visible   = visible_q;
	assign out_mask  = out_mask_q;

	// A rejected box never reports straddled planes.
	a_reject_clears_mask : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (visible || out_mask == '0))
		else $error("rejected box with non-empty plane mask");

	// Only planes that have a cell can appear in the result.
	a_mask_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((out_mask & ~MASK_LIVE) == '0))
		else $error("result mask names a plane without a cell");

	// The chain only backs up to the entry when the result side holds it.
	a_stall_source : assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_stall)
		else $error("entry stalled while the result side is free");

	// A result taken by the output register is presented in the next cycle.
	a_take_shows : assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> res_valid)
		else $error("captured result not presented");

endmodule

// File: rtl/fbc_cell.sv
module fbc_cell import fbc_pkg::*; #(
	parameter int unsigned CELL_INDEX = 0,
	parameter int unsigned CW         = COORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ctrl_t                in_ctrl,
	input  logic signed [CW-1:0] in_vec [3],
	input  logic        [CW-2:0] in_half [3],
	input  logic signed [CW-1:0] in_offset,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ctrl_t                out_ctrl,
	output logic signed [CW-1:0] out_vec [3],
	output logic        [CW-2:0] out_half [3],
	output logic signed [CW-1:0] out_offset
);

	localparam int unsigned PW = NORM_W + CW;
	localparam int unsigned AW = ABS_W + CW - 1;
	localparam int unsigned DW = CW + 18;
	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_INDEX);

	// Plane held by this cell.
	logic signed [NORM_W-1:0] norm_q [3];
	logic        [ABS_W-1:0]  abs_q [3];
	logic signed [CW-1:0]     offset_q;

	// Stage one: products.
	logic                 valid_s1;
	ctrl_t                ctrl_s1;
	logic signed [CW-1:0] vec_s1 [3];
	logic        [CW-2:0] half_s1 [3];
	logic signed [CW-1:0] offset_s1;
	logic signed [CW-1:0] pln_offs_s1;
	logic signed [PW-1:0] prod_n_s1 [3];
	logic        [AW-1:0] prod_a_s1 [3];

	// Stage two: distance and radius.
	logic                 valid_s2;
	ctrl_t                ctrl_s2;
	logic signed [CW-1:0] vec_s2 [3];
	logic        [CW-2:0] half_s2 [3];
	logic signed [CW-1:0] offset_s2;
	logic signed [DW-1:0] dist_s2;
	logic signed [DW-1:0] rad_s2;

	logic                 s2_ready;
	logic                 take_in;
	logic                 move_s2;
	logic signed [DW-1:0] dist_c;
	logic        [DW-1:0] rad_c;
	logic signed [DW:0]   near_c;

	// A stage advances when it is empty or its successor takes its item.
	assign s2_ready = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s2_ready;
	assign take_in  = in_valid && in_ready;
	assign move_s2  = valid_s1 && s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// A load for this slot rewrites the plane as it passes; later tests see it.
	always_ff @(posedge clk) begin
		if (take_in && in_ctrl.op == OP_LOAD && in_ctrl.slot == MY_SLOT) begin
			for (int k = 0; k < 3; k++) begin
				norm_q[k] <= in_vec[k][NORM_W-1:0];
				abs_q[k]  <= in_half[k][ABS_W-1:0];
			end
			offset_q <= in_offset;
		end
	end

	// Stage one multiplies the centre and half sizes by the plane terms.
	always_ff @(posedge clk) begin
		if (take_in) begin
			ctrl_s1     <= in_ctrl;
			offset_s1   <= in_offset;
			pln_offs_s1 <= offset_q;
			for (int k = 0; k < 3; k++) begin
				vec_s1[k]    <= in_vec[k];
				half_s1[k]   <= in_half[k];
				prod_n_s1[k] <= PW'(norm_q[k]) * PW'(in_vec[k]);
				prod_a_s1[k] <= AW'(abs_q[k]) * AW'(in_half[k]);
			end
		end
	end

	// Stage two sums the products into signed distance and radius.
	always_comb begin
		dist_c = DW'(prod_n_s1[0]) + DW'(prod_n_s1[1]) + DW'(prod_n_s1[2])
			+ (DW'(pln_offs_s1) <<< OFFSET_SHIFT);
		rad_c  = DW'(prod_a_s1[0]) + DW'(prod_a_s1[1]) + DW'(prod_a_s1[2]);
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			ctrl_s2   <= ctrl_s1;
			offset_s2 <= offset_s1;
			dist_s2   <= dist_c;
			rad_s2    <= signed'(rad_c);
			for (int k = 0; k < 3; k++) begin
				vec_s2[k]  <= vec_s1[k];
				half_s2[k] <= half_s1[k];
			end
		end
	end

	// Plane decision: fully behind rejects the box, fully in front drops the plane.
	assign near_c = (DW+1)'(dist_s2) + (DW+1)'(rad_s2);

	always_comb begin
		out_ctrl = ctrl_s2;
		if (ctrl_s2.op == OP_TEST && ctrl_s2.mask[CELL_INDEX]) begin
			priority if (near_c[DW]) begin
				out_ctrl.visible = 1'b0;
				out_ctrl.mask    = '0;
			end else if (!(dist_s2 < rad_s2)) begin
				out_ctrl.mask[CELL_INDEX] = 1'b0;
			end
		end
	end

	assign out_valid  = valid_s2;
	assign out_vec    = vec_s2;
	assign out_half   = half_s2;
	assign out_offset = offset_s2;

endmodule

// File: test/cull_checker.sv
module cull_checker import fbc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	input  logic                    cmd_stall,
	input  logic                    operation,
	input  logic [SLOT_W-1:0]       plane_slot,
	input  logic signed [VEC_W-1:0] vec_x,
	input  logic signed [VEC_W-1:0] vec_y,
	input  logic signed [VEC_W-1:0] vec_z,
	input  logic [HALF_W-1:0]       half_x,
	input  logic [HALF_W-1:0]       half_y,
	input  logic [HALF_W-1:0]       half_z,
	input  logic signed [VEC_W-1:0] plane_offset,
	input  logic [MASK_W-1:0]       in_mask,
	input  logic                    res_valid,
	input  logic                    res_stall,
	input  logic                    visible,
	input  logic [MASK_W-1:0]       out_mask,
	output int unsigned             mismatches,
	output int unsigned             pending
);

	typedef struct packed {
		logic              vis;
		logic [MASK_W-1:0] mask;
	} cull_verdict_t;

	// Our own copy of the plane slots, updated in transfer order.
	logic signed [NORM_W-1:0] plane_nrm [NUM_PLANES_DEF][3];
	logic        [ABS_W-1:0]  plane_mag [NUM_PLANES_DEF][3];
	logic signed [VEC_W-1:0]  plane_ofs [NUM_PLANES_DEF];

	cull_verdict_t expected_verdicts[$];
	cull_verdict_t want;
	int unsigned   fail_count;

	// Normals are clamped to the symmetric Q1.14 range before they are stored.
	function automatic logic signed [NORM_W-1:0] clamp_normal(logic signed [VEC_W-1:0] v);
		if (v > NORM_MAX)
			return NORM_W'(NORM_MAX);
		if (v < -NORM_MAX)
			return NORM_W'(-NORM_MAX);
		return v[NORM_W-1:0];
	endfunction

	function automatic void store_plane(logic [SLOT_W-1:0] slot, logic signed [VEC_W-1:0] nx,
			logic signed [VEC_W-1:0] ny, logic signed [VEC_W-1:0] nz,
			logic signed [VEC_W-1:0] ofs);
		logic signed [NORM_W-1:0] n [3];
		logic signed [NORM_W-1:0] m;
		// Loads aimed beyond the last slot are dropped by the block.
		if (slot >= NUM_PLANES_DEF)
			return;
		n[0] = clamp_normal(nx);
		n[1] = clamp_normal(ny);
		n[2] = clamp_normal(nz);
		for (int k = 0; k < 3; k++) begin
			m = (n[k] < 0) ? -n[k] : n[k];
			plane_nrm[slot][k] = n[k];
			plane_mag[slot][k] = m[ABS_W-1:0];
		end
		plane_ofs[slot] = ofs;
	endfunction

	// Signed distance against projected radius, planes taken in ascending slot order.
	function automatic cull_verdict_t predict_verdict(logic signed [VEC_W-1:0] cx,
			logic signed [VEC_W-1:0] cy, logic signed [VEC_W-1:0] cz,
			logic [HALF_W-1:0] hx, logic [HALF_W-1:0] hy, logic [HALF_W-1:0] hz,
			logic [MASK_W-1:0] mask);
		longint        centre [3];
		longint        extent [3];
		longint        plane_dist;
		longint        rad;
		longint        nk;
		longint        mk;
		cull_verdict_t v;
		centre[0] = cx;
		centre[1] = cy;
		centre[2] = cz;
		extent[0] = hx;
		extent[1] = hy;
		extent[2] = hz;
		v.vis = 1'b1;
		v.mask = '0;
		for (int p = 0; p < NUM_PLANES_DEF && p < MASK_W; p++) begin
			if (mask[p]) begin
				plane_dist = longint'(plane_ofs[p]) * (longint'(1) << OFFSET_SHIFT);
				rad = 0;
				for (int k = 0; k < 3; k++) begin
					nk = plane_nrm[p][k];
					mk = plane_mag[p][k];
					plane_dist += nk * centre[k];
					rad += mk * extent[k];
				end
				// Wholly behind this plane: reject and stop looking.
				if (plane_dist < -rad)
					return '0;
				if (plane_dist < rad)
					v.mask[p] = 1'b1;
			end
		end
		return v;
	endfunction

	// Results are checked before new commands are predicted; a test cannot finish in the
	// cycle of its own transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_verdicts.delete();
			fail_count = 0;
			mismatches <= 0;
			pending <= 0;
			for (int p = 0; p < NUM_PLANES_DEF; p++) begin
				for (int k = 0; k < 3; k++) begin
					plane_nrm[p][k] = '0;
					plane_mag[p][k] = '0;
				end
				plane_ofs[p] = '0;
			end
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_verdicts.size() == 0) begin
					if (fail_count < 10)
						$display("cull_checker: result with none outstanding: visible=%0b mask=%b",
							visible, out_mask);
					fail_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (visible !== want.vis || out_mask !== want.mask) begin
						if (fail_count < 10)
							$display("cull_checker: expected visible=%0b mask=%b, got visible=%0b mask=%b",
								want.vis, want.mask, visible, out_mask);
						fail_count++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				if (op_t'(operation) == OP_LOAD)
					store_plane(plane_slot, vec_x, vec_y, vec_z, plane_offset);
				else
					expected_verdicts.insert(expected_verdicts.size(),
						predict_verdict(vec_x, vec_y, vec_z, half_x, half_y, half_z, in_mask));
			end
			mismatches <= fail_count;
			pending <= expected_verdicts.size();
		end
	end

endmodule

// File: test/testbench.sv
module testbench;
	import fbc_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 1650;
	localparam int unsigned DRAIN_EVERY   = 400;
	localparam int unsigned HOLDOFF_LEN   = 300;
	localparam int unsigned HOLDOFF_EVERY = 550;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT   = 500000;

	typedef struct {
		op_t                    op;
		logic [SLOT_W-1:0]      slot;
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [VEC_W-1:0] vz;
		logic [HALF_W-1:0]      hx;
		logic [HALF_W-1:0]      hy;
		logic [HALF_W-1:0]      hz;
		logic signed [VEC_W-1:0] ofs;
		logic [MASK_W-1:0]      mask;
	} cull_cmd_t;

	typedef enum {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cmd_valid = 1'b0;
	logic                    cmd_stall;
	logic                    operation = 1'b0;
	logic [SLOT_W-1:0]       plane_slot = '0;
	logic signed [VEC_W-1:0] vec_x = '0;
	logic signed [VEC_W-1:0] vec_y = '0;
	logic signed [VEC_W-1:0] vec_z = '0;
	logic [HALF_W-1:0]       half_x = '0;
	logic [HALF_W-1:0]       half_y = '0;
	logic [HALF_W-1:0]       half_z = '0;
	logic signed [VEC_W-1:0] plane_offset = '0;
	logic [MASK_W-1:0]       in_mask = '0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic                    visible;
	logic [MASK_W-1:0]       out_mask;
	int unsigned             mismatches;
	int unsigned             pending;
	int unsigned             sent_items = 0;
	int unsigned             cycle_count = 0;

	frustum_box_cull_unit #(
		.NUM_PLANES (NUM_PLANES_DEF),
		.COORD_WIDTH(COORD_WIDTH_DEF)
	) u_dut (.*);

	cull_checker u_checker (.*);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("frustum_box_cull_unit test failed");
			$finish;
		end
	end

	function automatic logic signed [VEC_W-1:0] rand_span(int unsigned span);
		return int'($urandom_range(0, 2 * span)) - int'(span);
	endfunction

	// Centres are mostly near the origin so that planes actually cut the boxes.
	function automatic logic signed [VEC_W-1:0] rand_coord();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 12)
			return rand_span(1 << 16);
		if (sel < 17)
			return rand_span(1 << 24);
		return $urandom;
	endfunction

	function automatic logic [HALF_W-1:0] rand_half();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 12)
			return HALF_W'($urandom_range(0, 1 << 15));
		if (sel < 17)
			return HALF_W'($urandom_range(0, 1 << 23));
		return HALF_W'($urandom);
	endfunction

	// Most normals lie within range; full-width values exercise the clamp.
	function automatic logic signed [VEC_W-1:0] rand_normal();
		if ($urandom_range(0, 4) != 0)
			return rand_span(20000);
		return $urandom;
	endfunction

	function automatic logic signed [VEC_W-1:0] rand_offset();
		if ($urandom_range(0, 19) < 14)
			return rand_span(1 << 17);
		return $urandom;
	endfunction

	function automatic cull_cmd_t load_cmd(logic [SLOT_W-1:0] slot, logic signed [VEC_W-1:0] nx,
			logic signed [VEC_W-1:0] ny, logic signed [VEC_W-1:0] nz,
			logic signed [VEC_W-1:0] ofs);
		cull_cmd_t c;
		c.op = OP_LOAD;
		c.slot = slot;
		c.vx = nx;
		c.vy = ny;
		c.vz = nz;
		c.ofs = ofs;
		c.hx = HALF_W'($urandom);
		c.hy = HALF_W'($urandom);
		c.hz = HALF_W'($urandom);
		c.mask = MASK_W'($urandom);
		return c;
	endfunction

	function automatic cull_cmd_t test_cmd(logic signed [VEC_W-1:0] cx,
			logic signed [VEC_W-1:0] cy, logic signed [VEC_W-1:0] cz,
			logic [HALF_W-1:0] hx, logic [HALF_W-1:0] hy, logic [HALF_W-1:0] hz,
			logic [MASK_W-1:0] mask);
		cull_cmd_t c;
		c.op = OP_TEST;
		c.slot = SLOT_W'($urandom);
		c.vx = cx;
		c.vy = cy;
		c.vz = cz;
		c.hx = hx;
		c.hy = hy;
		c.hz = hz;
		c.ofs = $urandom;
		c.mask = mask;
		return c;
	endfunction

	// Every slot is loaded in the directed part, so any mask is legal afterwards.
	function automatic cull_cmd_t random_cmd();
		int unsigned sel;
		logic [MASK_W-1:0] mask;
		if ($urandom_range(0, 99) < 15)
			return load_cmd(SLOT_W'($urandom_range(0, 7)), rand_normal(), rand_normal(),
				rand_normal(), rand_offset());
		sel = $urandom_range(0, 19);
		if (sel < 2)
			mask = '1;
		else if (sel == 2)
			mask = '0;
		else
			mask = MASK_W'($urandom);
		return test_cmd(rand_coord(), rand_coord(), rand_coord(), rand_half(), rand_half(),
			rand_half(), mask);
	endfunction

	// Present one command and hold it until the transfer takes place.
	task automatic send_cmd(input cull_cmd_t c);
		@(negedge clk);
		cmd_valid <= 1'b1;
		operation <= c.op;
		plane_slot <= c.slot;
		vec_x <= c.vx;
		vec_y <= c.vy;
		vec_z <= c.vz;
		half_x <= c.hx;
		half_y <= c.hy;
		half_z <= c.hz;
		plane_offset <= c.ofs;
		in_mask <= c.mask;
		do
			@(posedge clk);
		while (cmd_stall);
		sent_items++;
	endtask

	// Stop offering and wait for every outstanding result to come back.
	task automatic go_quiet();
		@(negedge clk);
		cmd_valid <= 1'b0;
		wait (pending == 0);
	endtask

	// Result side: stall patterns that change now and then, plus long hold-offs that let
	// the pipeline fill and push back on the command side.
	initial begin
		rx_mode_t    mode;
		int unsigned mode_left;
		int unsigned period;
		int unsigned holdoff_left;
		int unsigned next_holdoff_at;
		mode = RX_FREE;
		mode_left = 0;
		period = 2;
		holdoff_left = 0;
		next_holdoff_at = HOLDOFF_EVERY / 2;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
				period = $urandom_range(2, 6);
			end
			mode_left--;
			if (holdoff_left == 0 && sent_items >= next_holdoff_at) begin
				holdoff_left = HOLDOFF_LEN;
				next_holdoff_at += HOLDOFF_EVERY;
			end
			if (holdoff_left > 0) begin
				res_stall <= 1'b1;
				holdoff_left--;
			end else begin
				case (mode)
					RX_FREE:     res_stall <= 1'b0;
					RX_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY:    res_stall <= ($urandom_range(0, 3) != 0);
					default:     res_stall <= (mode_left % period == 0);
				endcase
			end
		end
	end

	// Command side: directed commands, then random bursts with random gaps.
	initial begin
		int unsigned burst;
		int unsigned next_drain_at;
		int unsigned random_sent;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Plane slots, including clamped normals and extreme offsets.
		send_cmd(load_cmd(0, 16384, 0, 0, 0));
		send_cmd(load_cmd(1, 0, 16384, 0, -256));
		send_cmd(load_cmd(2, 32'sh7fffffff, 32'sh80000000, 32768, 32'sh7fffffff));
		send_cmd(load_cmd(3, -32768, 32767, -32767, 32'sh80000000));
		send_cmd(load_cmd(4, 0, 0, 16384, 0));
		send_cmd(load_cmd(5, 0, 0, -16384, 1000));
		// Slots past the last plane must leave the table untouched.
		send_cmd(load_cmd(6, 1, 1, 1, 5));
		send_cmd(load_cmd(7, -1, -1, -1, -5));

		// Empty mask, exact touching on either side, and a box one step behind.
		send_cmd(test_cmd(-5000, 7, 9, 1, 2, 3, 6'b000000));
		send_cmd(test_cmd(-100, 0, 0, 100, 0, 0, 6'b000001));
		send_cmd(test_cmd(100, 0, 0, 100, 0, 0, 6'b000001));
		send_cmd(test_cmd(-101, 0, 0, 100, 0, 0, 6'b000001));
		send_cmd(test_cmd(-1, 0, 0, 0, 0, 0, 6'b000001));
		// Point box at the origin against every plane: rejected by slot one.
		send_cmd(test_cmd(0, 0, 0, 0, 0, 0, 6'b111111));
		send_cmd(test_cmd(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 6'b111110));
		send_cmd(test_cmd(32'sh80000000, 32'sh80000000, 32'sh80000000,
			31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 6'b111111));
		send_cmd(test_cmd(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 6'b101100));
		send_cmd(test_cmd(0, 0, 0, 0, 0, 0, 6'b101100));
		send_cmd(test_cmd(0, 512, 0, 0, 0, 256, 6'b110010));
		// A reload followed at once by a test of the same slot.
		send_cmd(load_cmd(0, -16384, 0, 0, 1024));
		send_cmd(test_cmd(100, 0, 0, 2000, 0, 0, 6'b000001));
		send_cmd(test_cmd(5000, 0, 0, 0, 0, 0, 6'b000001));
		go_quiet();

		next_drain_at = DRAIN_EVERY;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && random_sent < RANDOM_ITEMS) begin
				send_cmd(random_cmd());
				random_sent++;
				burst--;
			end
			if (random_sent >= next_drain_at) begin
				go_quiet();
				next_drain_at += DRAIN_EVERY;
			end else if ($urandom_range(0, 4) != 0) begin
				@(negedge clk);
				cmd_valid <= 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end
		end

		go_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("frustum_box_cull_unit test passed");
		else
			$display("frustum_box_cull_unit test failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/fbc_pkg.sv
rtl/fbc_cell.sv
rtl/frustum_box_cull_unit.sv
test/cull_checker.sv
test/testbench.sv
